// ----- rtl/core/heap_sorter_assert.svh -----
`ifndef HEAP_SORTER_ASSERT_SVH
`define HEAP_SORTER_ASSERT_SVH

// Check that a condition holds in the same cycle as its trigger; idle in reset.
`define HS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("heap_sorter: same-cycle check failed");

// Check that a condition holds in the cycle after its trigger; idle in reset.
`define HS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("heap_sorter: next-cycle check failed");

`endif

// ----- rtl/core/hs_pkg.sv -----
package hs_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int VALUE_W        = 32;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_BUILD_RD,
		ST_BUILD_LD,
		ST_SIFT_RD,
		ST_SIFT_CMP,
		ST_EXT_RD,
		ST_EXT_SWAP,
		ST_EMIT
	} phase_t;

	typedef struct packed {
		logic vld;
		logic last;
		logic ovf;
	} emit_req_t;

endpackage

// ----- rtl/core/hs_ram.sv -----
module hs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ----- rtl/core/hs_emit.sv -----
module hs_emit
	import hs_pkg::*;
#(
	parameter int EW = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  emit_req_t                 req,
	input  logic signed [EW-1:0]      rdata,
	output logic                      strobe,
	output logic signed [VALUE_W-1:0] value_res,
	output logic                      last_res,
	output logic                      overflow
);

	emit_req_t                 req_s1;
	logic                      strobe_q;
	logic signed [VALUE_W-1:0] value_q;
	logic                      last_q;
	logic                      ovf_q;

	// Align the request with the registered memory read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1   <= '0;
			strobe_q <= 1'b0;
		end else begin
			req_s1   <= req;
			strobe_q <= req_s1.vld;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= VALUE_W'(rdata);
		last_q  <= req_s1.last;
		ovf_q   <= req_s1.ovf;
	end

	assign strobe    = strobe_q;
	assign value_res = value_q;
	assign last_res  = last_q;
	assign overflow  = ovf_q;

endmodule

// ----- rtl/core/heap_sorter.sv -----
// Channel  | Ports                          | Handshake
// request  | value, last                    | taken when start && !busy
// result   | value_res, last_res, overflow  | strobe, one cycle, cannot be held off
//
// Loading accepts one request per cycle; a request with last starts the sort.
// Each sift level reads both children, then compares and writes back; each
// extract step first reads the root, then moves it to the heap end.
// After the sort, results follow one per cycle, read from the store and registered.
// Asynchronous active-low reset returns the block to loading with an empty set.
// busy stays high from the cycle after a last request until the final read is issued.
`include "heap_sorter_assert.svh"

module heap_sorter
	import hs_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      last,
	output logic                      strobe,
	output logic signed [VALUE_W-1:0] value_res,
	output logic                      last_res,
	output logic                      overflow
);

	localparam int EW = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = AW + 2;

	phase_t state_q, state_d;

	logic [CW-1:0]        count_q;
	logic [CW-1:0]        heap_q;
	logic [AW-1:0]        build_q;
	logic [AW-1:0]        node_q;
	logic [AW-1:0]        k_q;
	logic                 ext_q;
	logic                 ovf_q;
	logic signed [EW-1:0] cur_q;

	logic                 we;
	logic [AW-1:0]        waddr;
	logic [EW-1:0]        wdata;
	logic [AW-1:0]        raddr_a;
	logic [AW-1:0]        raddr_b;
	logic signed [EW-1:0] rd_a;
	logic signed [EW-1:0] rd_b;
	emit_req_t            emit_req;

	logic                 accept;
	logic                 room;
	logic [CW-1:0]        count_inc;
	logic [IW-1:0]        left_idx;
	logic [IW-1:0]        right_idx;
	logic                 left_ok;
	logic                 right_ok;
	logic                 take_left;
	logic                 take_right;
	logic                 moved;
	logic signed [EW-1:0] left_max;
	logic signed [EW-1:0] big_val;
	logic [IW-1:0]        big_idx;
	logic                 emit_last;

	assign busy      = (state_q != ST_LOAD);
	assign accept    = start && !busy;
	assign room      = (count_q < CW'(DEPTH));
	assign count_inc = count_q + CW'(room);

	assign left_idx   = IW'({node_q, 1'b1});
	assign right_idx  = left_idx + IW'(1);
	assign left_ok    = (left_idx < IW'(heap_q));
	assign right_ok   = (right_idx < IW'(heap_q));
	assign take_left  = left_ok && (rd_a > cur_q);
	assign left_max   = take_left ? rd_a : cur_q;
	assign take_right = right_ok && (rd_b > left_max);
	assign moved      = take_left || take_right;
	assign big_val    = take_right ? rd_b : rd_a;
	assign big_idx    = take_right ? right_idx : left_idx;
	assign emit_last  = ((CW'(k_q) + CW'(1)) == count_q);

	hs_ram #(
		.WIDTH (EW),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rd_a),
		.raddr_b (raddr_b),
		.rdata_b (rd_b)
	);

	hs_emit #(
		.EW (EW)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (emit_req),
		.rdata     (rd_a),
		.strobe    (strobe),
		.value_res (value_res),
		.last_res  (last_res),
		.overflow  (overflow)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		we       = 1'b0;
		waddr    = AW'(count_q);
		wdata    = value[EW-1:0];
		raddr_a  = k_q;
		raddr_b  = AW'(heap_q - CW'(1));
		emit_req = '0;
		case (state_q)
			ST_LOAD: begin
				we = accept && room;
				if (accept && last) begin
					state_d = ST_BUILD_RD;
				end
			end
			ST_BUILD_RD: begin
				raddr_a = build_q - AW'(1);
				state_d = (build_q == '0) ? ST_EXT_RD : ST_BUILD_LD;
			end
			ST_BUILD_LD: begin
				state_d = ST_SIFT_RD;
			end
			ST_SIFT_RD: begin
				raddr_a = AW'(left_idx);
				raddr_b = AW'(right_idx);
				state_d = ST_SIFT_CMP;
			end
			ST_SIFT_CMP: begin
				// Move the larger child up; drop the carried value once it settles.
				we    = 1'b1;
				waddr = node_q;
				wdata = moved ? big_val : cur_q;
				if (moved) begin
					state_d = ST_SIFT_RD;
				end else begin
					state_d = ext_q ? ST_EXT_RD : ST_BUILD_RD;
				end
			end
			ST_EXT_RD: begin
				raddr_a = '0;
				state_d = (heap_q <= CW'(1)) ? ST_EMIT : ST_EXT_SWAP;
			end
			ST_EXT_SWAP: begin
				// Old root goes to the heap end; the end value is sifted from the root.
				we      = 1'b1;
				waddr   = AW'(heap_q - CW'(1));
				wdata   = rd_a;
				state_d = ST_SIFT_RD;
			end
			ST_EMIT: begin
				emit_req.vld  = 1'b1;
				emit_req.last = emit_last;
				emit_req.ovf  = ovf_q;
				if (emit_last) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			heap_q  <= '0;
			build_q <= '0;
			node_q  <= '0;
			k_q     <= '0;
			ext_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						count_q <= count_inc;
						if (!room) begin
							ovf_q <= 1'b1;
						end
						if (last) begin
							heap_q  <= count_inc;
							build_q <= AW'(count_inc >> 1);
							ext_q   <= 1'b0;
						end
					end
				end
				ST_BUILD_RD: begin
					if (build_q == '0) begin
						ext_q <= 1'b1;
					end else begin
						build_q <= build_q - AW'(1);
					end
				end
				ST_BUILD_LD: begin
					node_q <= build_q;
				end
				ST_SIFT_CMP: begin
					if (moved) begin
						node_q <= AW'(big_idx);
					end
				end
				ST_EXT_RD: begin
					k_q <= '0;
				end
				ST_EXT_SWAP: begin
					node_q <= '0;
					heap_q <= heap_q - CW'(1);
				end
				ST_EMIT: begin
					k_q <= k_q + AW'(1);
					if (emit_last) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						k_q     <= '0;
					end
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// Carried value of the sift; needs no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_BUILD_LD) begin
			cur_q <= rd_a;
		end else if (state_q == ST_EXT_SWAP) begin
			cur_q <= rd_b;
		end
	end

	`HS_ASSERT_NEXT(a_busy_after_last, clk, arst_n, start && !busy && last, busy)
	`HS_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`HS_ASSERT_NOW(a_sift_in_heap, clk, arst_n, state_q == ST_SIFT_CMP, CW'(node_q) < heap_q)
	`HS_ASSERT_NOW(a_emit_in_set, clk, arst_n, state_q == ST_EMIT, CW'(k_q) < count_q)

endmodule
